>>> hdl/ksq_pkg.sv
// Shared constants and codes for the keyboard scancode queue.
`default_nettype none

package ksq_pkg;

  // Field widths of the request and result channels
  localparam int SC_W        = 8;
  localparam int CODE_W      = 7;
  localparam int COUNT_OUT_W = 6;

  // Key-state map covers every 7-bit code
  localparam int MAP_DEPTH = 1 << CODE_W;

  // Highest key code that counts towards any_pressed (lowest is 1)
  localparam int LAST_COUNTED_KEY = 'h58;

  // Position of the release flag in a raw scancode
  localparam int BREAK_BIT = SC_W - 1;

  // Default ring depth
  localparam int BUF_DEPTH_DEF = 32;

  // Request function codes
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_POP   = 1'b1;

endpackage

`default_nettype wire

>>> hdl/ksq_if.sv
// Valid/ready channel interfaces for requests and results of the scancode queue.
`default_nettype none

interface ksq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [ksq_pkg::SC_W-1:0] scancode;

  modport source (output valid, output func, output scancode, input ready);
  modport sink   (input valid, input func, input scancode, output ready);
endinterface

interface ksq_out_if;
  logic                            valid;
  logic                            ready;
  logic [ksq_pkg::CODE_W-1:0]      popped_key;
  logic                            pop_valid;
  logic                            dropped;
  logic                            any_pressed;
  logic [ksq_pkg::COUNT_OUT_W-1:0] queued_count;

  modport source (output valid, output popped_key, output pop_valid, output dropped,
                  output any_pressed, output queued_count, input ready);
  modport sink   (input valid, input popped_key, input pop_valid, input dropped,
                  input any_pressed, input queued_count, output ready);
endinterface

`default_nettype wire

>>> hdl/keyboard_scancode_queue_core.sv
// Top level of the keyboard scancode queue: key-state map plus scancode ring.
//
// Usage:
//   in_chan  - request channel (valid/ready). func = FUNC_EVENT carries a raw
//              scancode: bit 7 set releases the key, clear presses it and queues
//              the code. func = FUNC_POP takes the oldest queued code.
//   out_chan - one result per request: popped key, pop/drop flags, whether any
//              key 1..0x58 is held and the queue fill after the request.
//   Throughput: one request per cycle while out_chan.ready stays high. Each
//   request is done in a single pass of logic between the input register and
//   the result register. An accepted request waits in the input register; its
//   result is then registered in the result register and presented until taken.
//   The ring memory is read every cycle at the next read pointer, with a
//   one-entry bypass for a write landing at that address, so a pop never waits.
//   Reset (rst_n low, synchronous): key map cleared, ring emptied, both
//   channels idle. Ring contents are not cleared; they are never read unwritten.
//   Stall: while out_chan.ready is low the result is held; one more request
//   may sit in the input register, after which in_chan.ready drops.
`default_nettype none

module keyboard_scancode_queue_core #(
  parameter int BUF_DEPTH = ksq_pkg::BUF_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ksq_in_if.sink     in_chan,
  ksq_out_if.source  out_chan
);

  localparam int PTR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  // Input register
  logic                     in_vld_r;
  logic                     func_r;
  logic [ksq_pkg::SC_W-1:0] sc_r;

  // Result register
  logic                            out_vld_r;
  logic [ksq_pkg::CODE_W-1:0]      popped_key_r;
  logic                            pop_valid_r;
  logic                            dropped_r;
  logic                            any_pressed_r;
  logic [ksq_pkg::COUNT_OUT_W-1:0] queued_count_r;

  // Queue state
  logic [ksq_pkg::MAP_DEPTH-1:0] key_map_r, key_map_nxt;
  logic [PTR_W-1:0]              rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]              wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;

  // Ring memory and its registered read port
  logic [ksq_pkg::CODE_W-1:0] ring_mem [BUF_DEPTH];
  logic [ksq_pkg::CODE_W-1:0] ring_rd_r;
  logic                       byp_r;
  logic [ksq_pkg::CODE_W-1:0] byp_data_r;
  logic [ksq_pkg::CODE_W-1:0] head_code;

  // Decode of the request held in the input register
  logic                       out_free;
  logic                       proc;
  logic                       is_pop;
  logic                       is_break;
  logic [ksq_pkg::CODE_W-1:0] code;
  logic                       empty;
  logic                       full;
  logic                       do_pop;
  logic                       do_push;
  logic                       drop;
  logic                       any_held;

  assign out_free      = !out_vld_r || out_chan.ready;
  assign proc          = in_vld_r && out_free;
  assign in_chan.ready = !in_vld_r || out_free;

  assign is_pop   = (func_r == ksq_pkg::FUNC_POP);
  assign is_break = sc_r[ksq_pkg::BREAK_BIT];
  assign code     = sc_r[ksq_pkg::CODE_W-1:0];
  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(BUF_DEPTH));

  assign do_pop  = proc && is_pop && !empty;
  assign do_push = proc && !is_pop && !is_break && !full;
  assign drop    = !is_pop && !is_break && full;

  // Oldest queued code: bypassed when it was written on the same edge as the read
  assign head_code = byp_r ? byp_data_r : ring_rd_r;

  always_comb begin
    key_map_nxt = key_map_r;
    if (proc && !is_pop) begin
      key_map_nxt[code] = !is_break;
    end
  end

  // Held-key summary reflects the map after this request; code 0 is excluded
  assign any_held = |key_map_nxt[ksq_pkg::LAST_COUNTED_KEY:1];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_nxt  = count_r - 1'b1;
    end else if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(BUF_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      count_nxt  = count_r + 1'b1;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      func_r <= in_chan.func;
      sc_r   <= in_chan.scancode;
    end
  end

  // Queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_map_r <= '0;
      rd_ptr_r  <= '0;
      wr_ptr_r  <= '0;
      count_r   <= '0;
      byp_r     <= 1'b0;
    end else begin
      key_map_r <= key_map_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      count_r   <= count_nxt;
      byp_r     <= do_push && (wr_ptr_r == rd_ptr_nxt);
    end
  end

  // Ring memory: one write port, one registered read at the next head
  always_ff @(posedge clk) begin
    if (do_push) begin
      ring_mem[wr_ptr_r] <= code;
    end
    ring_rd_r  <= ring_mem[rd_ptr_nxt];
    byp_data_r <= code;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      popped_key_r   <= do_pop ? head_code : '0;
      pop_valid_r    <= do_pop;
      dropped_r      <= drop;
      any_pressed_r  <= any_held;
      queued_count_r <= ksq_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.popped_key   = popped_key_r;
  assign out_chan.pop_valid    = pop_valid_r;
  assign out_chan.dropped      = dropped_r;
  assign out_chan.any_pressed  = any_pressed_r;
  assign out_chan.queued_count = queued_count_r;

endmodule

`default_nettype wire

>>> tb/keyboard_scancode_queue_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the keyboard scancode queue core.

// One result as the block presents it
typedef struct packed {
  logic [ksq_pkg::CODE_W-1:0]      popped_key;
  logic                            pop_valid;
  logic                            dropped;
  logic                            any_pressed;
  logic [ksq_pkg::COUNT_OUT_W-1:0] queued_count;
} key_result_t;

// Tracks the key map and the ring, and holds the results still owed by the block
class scancode_checker;
  int unsigned                   depth;
  logic [ksq_pkg::MAP_DEPTH-1:0] held_map;
  logic [ksq_pkg::CODE_W-1:0]    ring_mem[];
  int unsigned                   rd_slot;
  int unsigned                   wr_slot;
  int unsigned                   fill;
  key_result_t                   expected_results[$];
  int unsigned                   mismatches;
  int unsigned                   results_seen;
  int unsigned                   drops_seen;
  int unsigned                   pops_seen;

  function new(int unsigned buf_depth);
    depth        = buf_depth;
    ring_mem     = new[buf_depth];
    held_map     = '0;
    rd_slot      = 0;
    wr_slot      = 0;
    fill         = 0;
    mismatches   = 0;
    results_seen = 0;
    drops_seen   = 0;
    pops_seen    = 0;
  endfunction

  // Called once per accepted request
  function void note_request(logic func, logic [ksq_pkg::SC_W-1:0] scancode);
    key_result_t                res;
    logic [ksq_pkg::CODE_W-1:0] code;
    res  = '0;
    code = scancode[ksq_pkg::CODE_W-1:0];
    if (func == ksq_pkg::FUNC_POP) begin
      if (fill > 0) begin
        res.popped_key = ring_mem[rd_slot];
        res.pop_valid  = 1'b1;
        rd_slot        = (rd_slot == depth - 1) ? 0 : rd_slot + 1;
        fill--;
      end
    end else if (scancode[ksq_pkg::BREAK_BIT]) begin
      held_map[code] = 1'b0;
    end else begin
      held_map[code] = 1'b1;
      if (fill < depth) begin
        ring_mem[wr_slot] = code;
        wr_slot           = (wr_slot == depth - 1) ? 0 : wr_slot + 1;
        fill++;
      end else begin
        res.dropped = 1'b1;
      end
    end
    // key 0 is tracked but never counts as held
    res.any_pressed  = |held_map[ksq_pkg::LAST_COUNTED_KEY:1];
    res.queued_count = fill[ksq_pkg::COUNT_OUT_W-1:0];
    expected_results.push_back(res);
  endfunction

  function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%t: %s expected %0d, got %0d", $realtime, name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Called once per accepted result
  function void check_result(key_result_t got);
    key_result_t want;
    bit          bad;
    results_seen++;
    if (expected_results.size() == 0) begin
      if (mismatches < 10)
        $display("%t: result arrived with no request outstanding", $realtime);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (want.dropped)   drops_seen++;
    if (want.pop_valid) pops_seen++;
    bad = 1'b0;
    bad |= field_differs("popped_key",   8'(want.popped_key),   8'(got.popped_key));
    bad |= field_differs("pop_valid",    8'(want.pop_valid),    8'(got.pop_valid));
    bad |= field_differs("dropped",      8'(want.dropped),      8'(got.dropped));
    bad |= field_differs("any_pressed",  8'(want.any_pressed),  8'(got.any_pressed));
    bad |= field_differs("queued_count", 8'(want.queued_count), 8'(got.queued_count));
    if (bad) mismatches++;
  endfunction
endclass

module keyboard_scancode_queue_core_tb;

  localparam int KSQ_DEPTH   = ksq_pkg::BUF_DEPTH_DEF;
  localparam int PHASE_ITEMS = 310;   // random requests per idling phase
  localparam int STALL_LIMIT = 1000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD   = 80;    // receiver hold-off, well past the block's buffering
  localparam int TAIL_CYCLES = 8;     // margin after the last result before the summary

  logic clk;
  logic rst_n;

  ksq_in_if  in_chan ();
  ksq_out_if out_chan ();

  scancode_checker chk;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned requests_sent = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  bit          hold_wanted   = 1'b0;
  bit          hold_done     = 1'b0;

  // make codes pressed by fill bursts, released later by a release burst
  logic [ksq_pkg::CODE_W-1:0] held_keys[$];

  keyboard_scancode_queue_core #(
    .BUF_DEPTH(KSQ_DEPTH)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check on each handshake, then choose next cycle's ready.
  // Values read here are the ones from before the edge, as the block saw them.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      chk.check_result(key_result_t'{out_chan.popped_key, out_chan.pop_valid,
                                     out_chan.dropped, out_chan.any_pressed,
                                     out_chan.queued_count});
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (hold_wanted && !hold_done) begin
      // long back-pressure: the block fills and must drop in_chan.ready
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: any handshake on either channel counts as progress
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%t: no progress for %0d cycles", $realtime, STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one request, with an optional random gap first. valid stays high on
  // return so back-to-back requests never lower and raise it in one step.
  task automatic send_request(input logic func, input logic [ksq_pkg::SC_W-1:0] scancode);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_chan.valid    <= 1'b1;
    in_chan.func     <= func;
    in_chan.scancode <= scancode;
    do @(posedge clk); while (!in_chan.ready);
    chk.note_request(func, scancode);
    requests_sent++;
  endtask

  // Stop offering until every outstanding result has come back
  task automatic pause_until_drained();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (chk.expected_results.size() != 0);
  endtask

  // One burst of random traffic. Mostly well-formed typing, fill and drain
  // patterns so the ring runs full and empty often; some pure noise.
  task automatic random_burst();
    int unsigned                kind;
    int unsigned                n;
    logic [ksq_pkg::CODE_W-1:0] code;
    kind = $urandom_range(9);
    if (kind < 3) begin
      // typing: press, maybe read one back, then let go
      n = $urandom_range(6, 1);
      repeat (n) begin
        code = ksq_pkg::CODE_W'($urandom_range(127));
        send_request(ksq_pkg::FUNC_EVENT, {1'b0, code});
        if ($urandom_range(1)) send_request(ksq_pkg::FUNC_POP, 8'($urandom));
        send_request(ksq_pkg::FUNC_EVENT, {1'b1, code});
      end
    end else if (kind < 5) begin
      // fill: makes that often run the ring full and drop some
      n = $urandom_range(44, 24);
      repeat (n) begin
        code = ksq_pkg::CODE_W'($urandom_range(127));
        held_keys.push_back(code);
        send_request(ksq_pkg::FUNC_EVENT, {1'b0, code});
      end
    end else if (kind < 7) begin
      // let go of everything the fill bursts pressed
      while (held_keys.size() != 0)
        send_request(ksq_pkg::FUNC_EVENT, {1'b1, held_keys.pop_front()});
    end else if (kind < 9) begin
      // drain, often past empty; scancode field is don't-care on a pop
      n = $urandom_range(40, 10);
      repeat (n) send_request(ksq_pkg::FUNC_POP, 8'($urandom));
    end else begin
      n = $urandom_range(20, 5);
      repeat (n) send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned target;

    chk = new(KSQ_DEPTH);
    rst_n            <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.func     <= ksq_pkg::FUNC_EVENT;
    in_chan.scancode <= '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on empty, make code zero, codes either side of 0x58,
    // breaks of held and unheld keys, pops past empty with junk scancode.
    send_request(ksq_pkg::FUNC_POP,   8'h00);
    send_request(ksq_pkg::FUNC_EVENT, 8'h00);
    send_request(ksq_pkg::FUNC_EVENT, 8'h7f);
    send_request(ksq_pkg::FUNC_EVENT, 8'h01);
    send_request(ksq_pkg::FUNC_EVENT, 8'h58);
    send_request(ksq_pkg::FUNC_EVENT, 8'h59);
    send_request(ksq_pkg::FUNC_POP,   8'h00);
    send_request(ksq_pkg::FUNC_EVENT, 8'h81);
    send_request(ksq_pkg::FUNC_EVENT, 8'hd8);   // last counted key up: no counted key held now
    send_request(ksq_pkg::FUNC_EVENT, 8'h80);
    send_request(ksq_pkg::FUNC_EVENT, 8'hff);
    send_request(ksq_pkg::FUNC_EVENT, 8'hd9);
    send_request(ksq_pkg::FUNC_EVENT, 8'hc5);   // break of a key never pressed
    send_request(ksq_pkg::FUNC_POP,   8'h00);
    send_request(ksq_pkg::FUNC_POP,   8'hff);
    send_request(ksq_pkg::FUNC_POP,   8'h5a);
    send_request(ksq_pkg::FUNC_POP,   8'h00);
    send_request(ksq_pkg::FUNC_POP,   8'hff);   // empty again
    send_request(ksq_pkg::FUNC_EVENT, 8'h2a);
    send_request(ksq_pkg::FUNC_EVENT, 8'haa);
    send_request(ksq_pkg::FUNC_POP,   8'h00);
    pause_until_drained();

    // Phase one: sender mostly busy, receiver mostly stalling
    send_idle_pct = 17;
    recv_idle_pct = 78;
    target = requests_sent + PHASE_ITEMS;
    while (requests_sent < target) random_burst();
    pause_until_drained();

    // Phase two: roles swapped
    send_idle_pct = 78;
    recv_idle_pct = 17;
    target = requests_sent + PHASE_ITEMS;
    while (requests_sent < target) random_burst();
    pause_until_drained();

    // Phase three: no idling, opening with a long receiver hold-off while
    // requests keep coming so the input side has to back off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_wanted   = 1'b1;
    target = requests_sent + PHASE_ITEMS;
    while (requests_sent < target) random_burst();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests over three idling phases; checked %0d results.",
             requests_sent, chk.results_seen);
    $display("Pops returning a key: %0d, makes dropped on a full ring: %0d, mismatches: %0d.",
             chk.pops_seen, chk.drops_seen, chk.mismatches);
    if (chk.mismatches == 0 && chk.expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
